FILE: sv/apq_pkg.sv
package apq_pkg;

  // widths fixed by the beat fields
  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 8;
  localparam int unsigned FillW  = 5;

  // command carried in the opcode field
  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } opcode_e;

  // result status codes
  typedef enum logic [1:0] {
    StInserted  = 2'd0,
    StRemoved   = 2'd1,
    StOverflow  = 2'd2,
    StUnderflow = 2'd3
  } status_e;

  // one stored entry
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic [PrioW-1:0]         prio;
  } entry_t;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic ins;  // place new entry at its sorted position
    logic rem;  // pop the head, everything shifts toward cell 0
  } cell_ctl_t;

endpackage

FILE: sv/array_priority_queue.sv
// channel | handshake               | payload
// --------+-------------------------+-----------------------------------------
// in      | in_valid_i / in_stall_o | opcode_i, value_in_i, priority_in_i
// out     | out_valid_o / out_stall_i | value_out_o, status_o, fill_count_o
//
// The row of cells keeps entries sorted by priority, oldest first among
// equals, so an insert is one local compare per cell and a remove is one shift
// toward the head. One beat per cycle sustained unless the output stalls.
// The result beat is registered and shows up the cycle after the input beat.
// Reset empties the queue and drops the output valid; no clearing pass.
// A held result stalls the input only while out_stall_i is high.
module array_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic signed [apq_pkg::ValueW-1:0]  value_in_i,
  input  logic [apq_pkg::PrioW-1:0]          priority_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [apq_pkg::ValueW-1:0]  value_out_o,
  output logic [1:0]                         status_o,
  output logic [apq_pkg::FillW-1:0]          fill_count_o
);
  import apq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic            accept;
  logic            full;
  logic            empty;
  cell_ctl_t       ctl;
  entry_t          new_entry;
  entry_t          cell_entry [QUEUE_DEPTH];
  logic            cell_before [QUEUE_DEPTH];
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  status_e         status_d;
  logic signed [ValueW-1:0] value_d;

  logic                     out_valid_q;
  logic signed [ValueW-1:0] value_q;
  status_e                  status_q;
  logic [FillW-1:0]         fill_q;

  // input handshake: output register frees up when empty or being taken
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  assign ctl.ins = accept && (opcode_i == OpInsert) && !full;
  assign ctl.rem = accept && (opcode_i == OpRemove) && !empty;

  assign new_entry.value = value_in_i;
  assign new_entry.prio  = priority_in_i;

  // row of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_before;

    if (i == 0) begin : g_head
      assign left_entry  = new_entry;
      assign left_before = 1'b0;
    end else begin : g_mid
      assign left_entry  = cell_entry[i-1];
      assign left_before = cell_before[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    apq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .occ_i         (CntW'(i) < count_q),
      .new_i         (new_entry),
      .left_i        (left_entry),
      .left_before_i (left_before),
      .right_i       (right_entry),
      .before_o      (cell_before[i]),
      .entry_o       (cell_entry[i])
    );
  end

  // count update and result of this beat
  always_comb begin
    count_d  = count_q;
    value_d  = '0;
    status_d = StInserted;
    if (opcode_i == OpInsert) begin
      if (full) begin
        status_d = StOverflow;
      end else begin
        status_d = StInserted;
        count_d  = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = StUnderflow;
      end else begin
        status_d = StRemoved;
        value_d  = cell_entry[0].value;
        count_d  = count_q - CntW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= value_d;
      status_q <= status_d;
      fill_q   <= FillW'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_out_o  = value_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

endmodule

FILE: sv/apq_cell.sv
module apq_cell (
  input  logic               clk_i,
  input  apq_pkg::cell_ctl_t ctl_i,
  input  logic               occ_i,
  input  apq_pkg::entry_t    new_i,
  input  apq_pkg::entry_t    left_i,
  input  logic               left_before_i,
  input  apq_pkg::entry_t    right_i,
  output logic               before_o,
  output apq_pkg::entry_t    entry_o
);
  import apq_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // new entry lands at or ahead of this cell; ties stay behind older entries
  assign before_o = !occ_i || (new_i.prio > entry_q.prio);

  // shift left on remove, shift right or capture on insert
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.rem) begin
      entry_d = right_i;
    end else if (ctl_i.ins && before_o) begin
      entry_d = left_before_i ? left_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
